FILE: hdl/lltd_pkg.sv
// Package for the least-loaded task dispatcher: payload types, codes and the
// sequencer microprogram. No dependencies; used by the interfaces and the top level.
package lltd_pkg;

  // Field widths fixed by the block's interface
  localparam int TASK_W     = 16;
  localparam int SUM_W      = 40;
  localparam int IDX_OUT_W  = 5;
  localparam int LOAD_OUT_W = 32;
  localparam int MODE_W     = 2;
  localparam int SRV_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVERS_IN_USE = 1'd1;

  // Policy modes (the unused code behaves as least loaded)
  localparam logic [MODE_W-1:0] MODE_RR     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEFER  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Operations
  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Transaction payloads
  typedef struct packed {
    logic              operation;
    logic [TASK_W-1:0] task_load;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  server_index;
    logic [LOAD_OUT_W-1:0] server_new_load;
    logic [SUM_W-1:0]      total_load;
    logic                  saturated;
  } out_item_t;

  // Microprogram step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] ST_SCAN_T    = 4'd1;
  localparam logic [PC_W-1:0] ST_SCAN_T_LP = 4'd2;
  localparam logic [PC_W-1:0] ST_TGT       = 4'd3;
  localparam logic [PC_W-1:0] ST_RD        = 4'd4;
  localparam logic [PC_W-1:0] ST_ADD       = 4'd5;
  localparam logic [PC_W-1:0] ST_SUM       = 4'd6;
  localparam logic [PC_W-1:0] ST_OUT       = 4'd7;
  localparam logic [PC_W-1:0] ST_SCAN_P    = 4'd8;
  localparam logic [PC_W-1:0] ST_SCAN_P_LP = 4'd9;
  localparam logic [PC_W-1:0] ST_SET_PTR   = 4'd10;
  localparam logic [PC_W-1:0] ST_CLR       = 4'd11;

  // Sequencer jump kinds
  typedef enum logic [2:0] {
    JMP_NEXT,      // fall through to the next step
    JMP_ALWAYS,    // go to target
    JMP_DISPATCH,  // wait for a transaction, branch on operation and mode
    JMP_LOOP,      // repeat while the scan has servers left
    JMP_IF_DEFER,  // go to target in deferred mode, else fall through
    JMP_OUT        // go to target once the output register is free
  } jmp_e;

  // One control word per step
  typedef struct packed {
    logic            wait_in;
    logic            scan_init;
    logic            scan_step;
    logic            set_tgt;
    logic            rd_tgt;
    logic            do_add;
    logic            do_sum;
    logic            set_ptr;
    logic            do_clr;
    logic            do_out;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Microprogram ROM
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c        = '0;
    c.jmp    = JMP_NEXT;
    c.target = ST_IDLE;
    case (pc)
      ST_IDLE: begin
        c.wait_in = 1'b1;
        c.jmp     = JMP_DISPATCH;
      end
      ST_SCAN_T:    c.scan_init = 1'b1;
      ST_SCAN_T_LP: begin
        c.scan_step = 1'b1;
        c.jmp       = JMP_LOOP;
      end
      ST_TGT:       c.set_tgt = 1'b1;
      ST_RD:        c.rd_tgt  = 1'b1;
      ST_ADD:       c.do_add  = 1'b1;
      ST_SUM: begin
        c.do_sum = 1'b1;
        c.jmp    = JMP_IF_DEFER;
        c.target = ST_SCAN_P;
      end
      ST_OUT: begin
        c.do_out = 1'b1;
        c.jmp    = JMP_OUT;
        c.target = ST_IDLE;
      end
      ST_SCAN_P:    c.scan_init = 1'b1;
      ST_SCAN_P_LP: begin
        c.scan_step = 1'b1;
        c.jmp       = JMP_LOOP;
      end
      ST_SET_PTR: begin
        c.set_ptr = 1'b1;
        c.jmp     = JMP_ALWAYS;
        c.target  = ST_OUT;
      end
      ST_CLR: begin
        c.do_clr = 1'b1;
        c.jmp    = JMP_ALWAYS;
        c.target = ST_OUT;
      end
      default: begin
        c.jmp    = JMP_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/lltd_if.sv
// Valid/ready channel interfaces for the dispatcher's input and result streams.
// Depends on lltd_pkg for the payload types.
interface lltd_in_if;
  logic               valid;
  logic               ready;
  lltd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lltd_out_if;
  logic                valid;
  logic                ready;
  lltd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/lltd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lltd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/least_loaded_task_dispatcher.sv
// Least-loaded task dispatcher, microcoded: a step counter walks a ROM program.
// Round robin reads the pointer's load, adds, sums, then outputs. Least loaded
// first scans the n servers in use (one load read per cycle from the RAM).
// Deferred serves the pointer, then scans to set it. One transaction at a time.
// Reset (rst_ni, async): loads read as zero through per-server valid bits,
// pointer and sum zero, policy least loaded, all servers in use; no clearing pass.
module least_loaded_task_dispatcher #(
  parameter int MAX_SERVERS = 32,
  parameter int LOAD_WIDTH  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lltd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lltd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lltd_in_if.sink                        in_i,
  lltd_out_if.source                     out_o
);

  import lltd_pkg::*;

  localparam int IDX_W = $clog2(MAX_SERVERS);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  // Sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           uc;

  // Configuration
  logic [MODE_W-1:0] policy_q;
  logic [SRV_W-1:0]  srv_q;

  // Datapath state
  logic [MAX_SERVERS-1:0] vld_q, vld_d;
  logic [IDX_W-1:0]       ptr_q, ptr_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [TASK_W-1:0]      task_q, task_d;
  logic [IDX_W-1:0]       tgt_q, tgt_d;
  logic [LOAD_WIDTH-1:0]  nl_q, nl_d;
  logic [TASK_W-1:0]      delta_q, delta_d;
  logic                   sat_q, sat_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [LOAD_WIDTH-1:0]  best_load_q, best_load_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  // RAM read side
  logic [IDX_W-1:0]      rd_addr, rd_addr_q;
  logic                  rd_vld_q;
  logic [LOAD_WIDTH-1:0] rd_data, rd_load;
  logic                  ram_we;

  // Helpers
  logic [31:0]         n_full;
  logic [CNT_W-1:0]    n_act;
  logic [IDX_W-1:0]    eff_ptr, rr_next;
  logic                mode_least, in_acc, scan_more, out_free;
  logic [LOAD_WIDTH:0] add_ext;
  logic [SUM_W:0]      sum_ext;
  logic [LOAD_WIDTH-1:0] nl_sat;
  logic [LOAD_WIDTH-1:0] diff;

  assign uc = ucode(pc_q);

  // Active server count, clamped to 1..MAX_SERVERS
  always_comb begin
    if (srv_q == '0) begin
      n_full = 32'd1;
    end else if (32'(srv_q) > 32'(MAX_SERVERS)) begin
      n_full = 32'(MAX_SERVERS);
    end else begin
      n_full = 32'(srv_q);
    end
  end
  assign n_act = n_full[CNT_W-1:0];

  // Stale pointer reads as server 0
  assign eff_ptr = (32'(ptr_q) >= 32'(n_act)) ? '0 : ptr_q;
  assign rr_next = (32'(tgt_q) + 32'd1 == 32'(n_act)) ? '0 : IDX_W'(32'(tgt_q) + 32'd1);

  assign mode_least = (policy_q == MODE_LEAST) || (policy_q == MODE_UNUSED);
  assign in_i.ready = uc.wait_in;
  assign in_acc     = in_i.valid && in_i.ready;
  assign scan_more  = 32'(cnt_q) < 32'(n_act);
  assign out_free   = !out_valid_q || out_o.ready;

  // Never-written or cleared entries read as zero
  assign rd_load = rd_vld_q ? rd_data : '0;
  assign add_ext = {1'b0, rd_load} + (LOAD_WIDTH+1)'(task_q);
  assign nl_sat  = add_ext[LOAD_WIDTH] ? '1 : add_ext[LOAD_WIDTH-1:0];
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(delta_q);
  assign diff    = nl_sat - rd_load;
  assign ram_we  = uc.do_add;

  lltd_ram #(
    .WIDTH (LOAD_WIDTH),
    .DEPTH (MAX_SERVERS)
  ) u_loads (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_q),
    .wdata_i (nl_d),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Datapath driven by the control word
  always_comb begin
    vld_d       = vld_q;
    ptr_d       = ptr_q;
    sum_d       = sum_q;
    task_d      = task_q;
    tgt_d       = tgt_q;
    nl_d        = nl_q;
    delta_d     = delta_q;
    sat_d       = sat_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_load_d = best_load_q;
    rd_addr     = '0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Latch the transaction; pointer modes target the pointer's server
    if (uc.wait_in && in_acc) begin
      task_d = in_i.data.task_load;
      tgt_d  = eff_ptr;
      sat_d  = 1'b0;
    end

    // Target load read ahead of the update
    if (uc.rd_tgt) begin
      rd_addr = tgt_q;
    end

    // Minimum scan: issue one read per cycle, compare the previous one
    if (uc.scan_init) begin
      rd_addr     = '0;
      cnt_d       = CNT_W'(1);
      best_idx_d  = '0;
      best_load_d = '1;
    end
    if (uc.scan_step) begin
      if (rd_load < best_load_q) begin
        best_load_d = rd_load;
        best_idx_d  = rd_addr_q;
      end
      if (scan_more) begin
        rd_addr = cnt_q[IDX_W-1:0];
        cnt_d   = CNT_W'(32'(cnt_q) + 32'd1);
      end
    end
    if (uc.set_tgt) begin
      tgt_d = best_idx_q;
    end
    if (uc.set_ptr) begin
      ptr_d = best_idx_q;
    end

    // Saturating load update and write-back
    if (uc.do_add) begin
      if (add_ext[LOAD_WIDTH]) begin
        sat_d = 1'b1;
      end
      nl_d           = nl_sat;
      delta_d        = diff[TASK_W-1:0];
      vld_d[tgt_q]   = 1'b1;
    end

    // Saturating sum, round-robin pointer advance
    if (uc.do_sum) begin
      if (sum_ext[SUM_W]) begin
        sum_d = '1;
        sat_d = 1'b1;
      end else begin
        sum_d = sum_ext[SUM_W-1:0];
      end
      if (policy_q == MODE_RR) begin
        ptr_d = rr_next;
      end
    end

    if (uc.do_clr) begin
      vld_d = '0;
      ptr_d = '0;
      sum_d = '0;
      tgt_d = '0;
      nl_d  = '0;
      sat_d = 1'b0;
    end

    // Result register
    if (uc.do_out && out_free) begin
      out_valid_d                = 1'b1;
      out_data_d.server_index    = IDX_OUT_W'(tgt_q);
      out_data_d.server_new_load = LOAD_OUT_W'(nl_q);
      out_data_d.total_load      = sum_q;
      out_data_d.saturated       = sat_q;
    end
  end

  // Next step
  always_comb begin
    pc_d = pc_q;
    case (uc.jmp)
      JMP_NEXT:   pc_d = PC_W'(pc_q + 1'b1);
      JMP_ALWAYS: pc_d = uc.target;
      JMP_DISPATCH: begin
        if (in_acc) begin
          if (in_i.data.operation == OP_CLEAR) begin
            pc_d = ST_CLR;
          end else if (mode_least) begin
            pc_d = ST_SCAN_T;
          end else begin
            pc_d = ST_RD;
          end
        end
      end
      JMP_LOOP: begin
        if (!scan_more) begin
          pc_d = PC_W'(pc_q + 1'b1);
        end
      end
      JMP_IF_DEFER: begin
        if (policy_q == MODE_DEFER) begin
          pc_d = uc.target;
        end else begin
          pc_d = PC_W'(pc_q + 1'b1);
        end
      end
      JMP_OUT: begin
        if (out_free) begin
          pc_d = uc.target;
        end
      end
      default: pc_d = ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      policy_q    <= MODE_LEAST;
      srv_q       <= SRV_W'(32);
      vld_q       <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      vld_q       <= vld_d;
      ptr_q       <= ptr_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLICY_MODE:    policy_q <= cfg_data_i[MODE_W-1:0];
          REG_SERVERS_IN_USE: srv_q    <= cfg_data_i[SRV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    task_q      <= task_d;
    tgt_q       <= tgt_d;
    nl_q        <= nl_d;
    delta_q     <= delta_d;
    sat_q       <= sat_d;
    cnt_q       <= cnt_d;
    best_idx_q  <= best_idx_d;
    best_load_q <= best_load_d;
    rd_addr_q   <= rd_addr;
    rd_vld_q    <= vld_q[rd_addr];
    out_data_q  <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
